@@ src/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define QB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define QB_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/qbuv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbuv_pkg
// Shared widths, types and helpers of the quad UV interpolator.
// ----------------------------------------------------------------------------
package qbuv_pkg;

  localparam int CW   = 32;            // coordinate width
  localparam int DW   = CW + 1;        // coordinate difference
  localparam int PW   = 2 * DW;        // product of two differences
  localparam int XW   = PW + 1;        // cross product
  localparam int SPL  = 34;            // low slice of a split cross product
  localparam int LPW  = SPL + 1 + DW;  // low partial product
  localparam int HPW  = (XW - SPL) + DW; // high partial product
  localparam int NW   = 100;           // blended numerator
  localparam int QW   = 34;            // quotient bits of 2|n|/|d|
  localparam int RW   = NW + 1;        // divider remainder
  localparam int DVW  = XW - 1;        // divisor magnitude
  localparam int CFGW = 64;
  localparam int IDXW = 3;

  typedef enum logic [IDXW-1:0] {
    REG_C0_POS = 3'd0,
    REG_C1_POS = 3'd1,
    REG_C2_POS = 3'd2,
    REG_C3_POS = 3'd3,
    REG_C0_UV  = 3'd4,
    REG_C1_UV  = 3'd5,
    REG_C2_UV  = 3'd6,
    REG_C3_UV  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [3:0][CFGW-1:0] pos;
    logic [3:0][CFGW-1:0] uv;
  } corner_cfg_t;

  typedef struct packed {
    logic                 sel;
    logic signed [XW-1:0] d;
    logic signed [XW-1:0] cb;
    logic signed [XW-1:0] cc;
  } geo_t;

  typedef struct packed {
    logic                 sel;
    logic signed [XW-1:0] d;
    logic signed [NW-1:0] nu;
    logic signed [NW-1:0] nv;
  } num_t;

  typedef struct packed {
    logic signed [CW-1:0] tex_u;
    logic signed [CW-1:0] tex_v;
    logic                 sel;
    logic                 degenerate;
  } res_t;

  function automatic logic signed [CW-1:0] lo_word(input logic [CFGW-1:0] w);
    return $signed(w[CW-1:0]);
  endfunction

  function automatic logic signed [CW-1:0] hi_word(input logic [CFGW-1:0] w);
    return $signed(w[CFGW-1:CW]);
  endfunction

  // a - b of two signed coordinates, one bit wider
  function automatic logic signed [DW-1:0] sub_ext(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
    return $signed({a[CW-1], a}) - $signed({b[CW-1], b});
  endfunction

endpackage

@@ src/qbuv_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbuv channel interfaces
// Point, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface qbuv_in_if import qbuv_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] surface_s;
  logic signed [CW-1:0] surface_t;
  modport source(output valid, surface_s, surface_t, input ready);
  modport sink(input valid, surface_s, surface_t, output ready);
endinterface

interface qbuv_out_if import qbuv_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] tex_u;
  logic signed [CW-1:0] tex_v;
  logic                 tri_select;
  logic                 degenerate;
  modport source(output valid, tex_u, tex_v, tri_select, degenerate, input ready);
  modport sink(input valid, tex_u, tex_v, tri_select, degenerate, output ready);
endinterface

interface qbuv_cfg_if import qbuv_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IDXW-1:0] index;
  logic [CFGW-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ src/quad_barycentric_uv_interp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_barycentric_uv_interp
// Maps a surface point to a texture coordinate inside a configured quad.
// ----------------------------------------------------------------------------
//   Channel  Port    Direction  Payload
//   point    in_ch   sink       surface_s, surface_t (signed Q16.16)
//   result   out_ch  source     tex_u, tex_v, tri_select, degenerate
//   config   cfg_ch  sink       index (0..7), data (64 bits)
//
// One item enters per clock unless the pipeline stalls; the divider forms
// each quotient in 34 one-bit stages ahead of the output register.
// Reset is synchronous and active low; it clears all valid bits and sets
// every corner register to zero.
// The pipeline stalls only when the output register holds an untaken item
// and the last divider stage is full, so bubbles are squeezed out meanwhile.
// Configuration writes are always taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quad_barycentric_uv_interp import qbuv_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  qbuv_in_if.sink      in_ch,
  qbuv_out_if.source   out_ch,
  qbuv_cfg_if.sink     cfg_ch
);

  // Corner positions and UVs, written through the configuration channel.
  corner_cfg_t cfg_r;

  logic pipe_en;
  logic out_ld;
  logic geo_vld, num_vld, div_vld;
  geo_t geo;
  num_t num;
  res_t div_res;

  logic out_vld_r;
  res_t res_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_C0_POS: cfg_r.pos[0] <= cfg_ch.data;
        REG_C1_POS: cfg_r.pos[1] <= cfg_ch.data;
        REG_C2_POS: cfg_r.pos[2] <= cfg_ch.data;
        REG_C3_POS: cfg_r.pos[3] <= cfg_ch.data;
        REG_C0_UV:  cfg_r.uv[0]  <= cfg_ch.data;
        REG_C1_UV:  cfg_r.uv[1]  <= cfg_ch.data;
        REG_C2_UV:  cfg_r.uv[2]  <= cfg_ch.data;
        REG_C3_UV:  cfg_r.uv[3]  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // The output register loads whenever it is empty or being drained. The
  // whole pipeline shifts unless that would push a result into a full
  // output register.
  assign out_ld      = !out_vld_r || out_ch.ready;
  assign pipe_en     = out_ld || !div_vld;
  assign in_ch.ready = pipe_en;

  qbuv_tri_setup u_setup (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .in_vld  (in_ch.valid),
    .pt_s    (in_ch.surface_s),
    .pt_t    (in_ch.surface_t),
    .cfg     (cfg_r),
    .out_vld (geo_vld),
    .geo     (geo)
  );

  qbuv_blend u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .in_vld  (geo_vld),
    .geo     (geo),
    .cfg     (cfg_r),
    .out_vld (num_vld),
    .num     (num)
  );

  qbuv_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .in_vld  (num_vld),
    .num     (num),
    .out_vld (div_vld),
    .res     (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_ld) begin
      out_vld_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      res_r <= div_res;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.tex_u      = res_r.tex_u;
  assign out_ch.tex_v      = res_r.tex_v;
  assign out_ch.tri_select = res_r.sel;
  assign out_ch.degenerate = res_r.degenerate;

  // A degenerate triangle always reports a zero texture coordinate.
  `QB_ASSERT(a_deg_zero_uv, out_vld_r && res_r.degenerate |-> res_r.tex_u == '0 && res_r.tex_v == '0, "degenerate result with nonzero uv")
  // The pipeline only freezes with a full last stage behind a blocked output.
  `QB_ASSERT(a_stall_cause, !pipe_en |-> out_vld_r && !out_ch.ready && div_vld, "pipeline stalled without cause")
  // Reset empties the divider tail and the output register.
  `QB_ASSERT_ALL(a_reset_empty, !rst_n |=> !out_vld_r && !div_vld, "valid item after reset")

endmodule

@@ src/qbuv_tri_setup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbuv_tri_setup
// Picks the triangle and forms the three cross products (six stages).
// ----------------------------------------------------------------------------
module qbuv_tri_setup import qbuv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [CW-1:0] pt_s,
  input  logic signed [CW-1:0] pt_t,
  input  corner_cfg_t          cfg,
  output logic                 out_vld,
  output geo_t                 geo
);

  logic [5:0] vld_r;

  logic signed [CW-1:0] s1_px_r, s1_py_r, s2_px_r, s2_py_r, s3_px_r, s3_py_r;
  logic signed [DW-1:0] s1_ax_r, s1_ay_r, s1_bx_r, s1_by_r;
  logic signed [PW-1:0] s2_m1_r, s2_m2_r;
  logic                 s3_sel_r, s4_sel_r, s5_sel_r, geo_sel_r;
  logic signed [DW-1:0] e0x_r, e0y_r, e1x_r, e1y_r, e2x_r, e2y_r;
  logic signed [PW-1:0] pd1_r, pd2_r, pb1_r, pb2_r, pc1_r, pc2_r;
  logic signed [XW-1:0] d_r, cb_r, cc_r;

  logic signed [XW-1:0] side;
  logic [CFGW-1:0]      t0, t1, t2;

  always_comb begin
    side = XW'(s2_m1_r) - XW'(s2_m2_r);
    t0   = s3_sel_r ? cfg.pos[1] : cfg.pos[0];
    t1   = s3_sel_r ? cfg.pos[3] : cfg.pos[1];
    t2   = cfg.pos[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // diagonal vector and point offset from corner 1
      s1_px_r <= pt_s;
      s1_py_r <= pt_t;
      s1_ax_r <= sub_ext(lo_word(cfg.pos[2]), lo_word(cfg.pos[1]));
      s1_ay_r <= sub_ext(hi_word(cfg.pos[2]), hi_word(cfg.pos[1]));
      s1_bx_r <= sub_ext(pt_s, lo_word(cfg.pos[1]));
      s1_by_r <= sub_ext(pt_t, hi_word(cfg.pos[1]));

      s2_px_r <= s1_px_r;
      s2_py_r <= s1_py_r;
      s2_m1_r <= s1_ax_r * s1_by_r;
      s2_m2_r <= s1_ay_r * s1_bx_r;

      // a point on the diagonal goes to the second triangle
      s3_px_r  <= s2_px_r;
      s3_py_r  <= s2_py_r;
      s3_sel_r <= side[XW-1] | (side == '0);

      s4_sel_r <= s3_sel_r;
      e0x_r <= sub_ext(lo_word(t1), lo_word(t0));
      e0y_r <= sub_ext(hi_word(t1), hi_word(t0));
      e1x_r <= sub_ext(lo_word(t2), lo_word(t0));
      e1y_r <= sub_ext(hi_word(t2), hi_word(t0));
      e2x_r <= sub_ext(s3_px_r, lo_word(t0));
      e2y_r <= sub_ext(s3_py_r, hi_word(t0));

      s5_sel_r <= s4_sel_r;
      pd1_r <= e0x_r * e1y_r;
      pd2_r <= e0y_r * e1x_r;
      pb1_r <= e2x_r * e1y_r;
      pb2_r <= e2y_r * e1x_r;
      pc1_r <= e0x_r * e2y_r;
      pc2_r <= e0y_r * e2x_r;

      geo_sel_r <= s5_sel_r;
      d_r  <= XW'(pd1_r) - XW'(pd2_r);
      cb_r <= XW'(pb1_r) - XW'(pb2_r);
      cc_r <= XW'(pc1_r) - XW'(pc2_r);
    end
  end

  assign out_vld = vld_r[5];
  assign geo     = '{sel: geo_sel_r, d: d_r, cb: cb_r, cc: cc_r};

endmodule

@@ src/qbuv_blend.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbuv_blend
// Forms the scaled numerators d*a0 + cb*(a1-a0) + cc*(a2-a0) for u and v.
// ----------------------------------------------------------------------------
module qbuv_blend import qbuv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  geo_t        geo,
  input  corner_cfg_t cfg,
  output logic        out_vld,
  output num_t        num
);

  localparam int NT = 6;

  logic [2:0] vld_r;

  logic signed [LPW-1:0] lo_r [NT];
  logic signed [HPW-1:0] hi_r [NT];
  logic signed [NW-1:0]  term_r [NT];
  logic signed [XW-1:0]  d7_r, d8_r, d9_r;
  logic                  sel7_r, sel8_r, sel9_r;
  logic signed [NW-1:0]  nu_r, nv_r;

  logic [CFGW-1:0]      a0, a1, a2;
  logic signed [XW-1:0] op_x [NT];
  logic signed [DW-1:0] op_a [NT];

  always_comb begin
    a0 = geo.sel ? cfg.uv[1] : cfg.uv[0];
    a1 = geo.sel ? cfg.uv[3] : cfg.uv[1];
    a2 = cfg.uv[2];
    op_x[0] = geo.d;
    op_x[1] = geo.cb;
    op_x[2] = geo.cc;
    op_x[3] = geo.d;
    op_x[4] = geo.cb;
    op_x[5] = geo.cc;
    op_a[0] = DW'(lo_word(a0));
    op_a[1] = sub_ext(lo_word(a1), lo_word(a0));
    op_a[2] = sub_ext(lo_word(a2), lo_word(a0));
    op_a[3] = DW'(hi_word(a0));
    op_a[4] = sub_ext(hi_word(a1), hi_word(a0));
    op_a[5] = sub_ext(hi_word(a2), hi_word(a0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // each wide product is split into a low and a high partial product
      for (int j = 0; j < NT; j++) begin
        lo_r[j]   <= $signed({1'b0, op_x[j][SPL-1:0]}) * op_a[j];
        hi_r[j]   <= $signed(op_x[j][XW-1:SPL]) * op_a[j];
        term_r[j] <= (NW'(hi_r[j]) <<< SPL) + NW'(lo_r[j]);
      end
      d7_r   <= geo.d;
      sel7_r <= geo.sel;
      d8_r   <= d7_r;
      sel8_r <= sel7_r;
      d9_r   <= d8_r;
      sel9_r <= sel8_r;
      nu_r   <= term_r[0] + term_r[1] + term_r[2];
      nv_r   <= term_r[3] + term_r[4] + term_r[5];
    end
  end

  assign out_vld = vld_r[2];
  assign num     = '{sel: sel9_r, d: d9_r, nu: nu_r, nv: nv_r};

endmodule

@@ src/qbuv_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbuv_div
// Pipelined restoring divider, one quotient bit per stage, with rounding
// to nearest (ties away from zero) and 32-bit saturation.
// ----------------------------------------------------------------------------
module qbuv_div import qbuv_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_vld,
  input  num_t num,
  output logic out_vld,
  output res_t res
);

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QW-1:0] quo;
    logic          neg;
    logic          ovf;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [1:0]  lane;
    logic [DVW-1:0]   dvs;
    logic             sel;
    logic             deg;
  } div_stage_t;

  logic [QW:0] vld_r;
  div_stage_t  stg_r   [QW+1];
  div_stage_t  stg_nxt [QW+1];
  logic        fin_vld_r;
  res_t        res_r, res_nxt;

  always_comb begin
    logic [RW-1:0]        ds;
    logic [DVW-1:0]       dmag;
    logic signed [NW-1:0] n;
    logic [NW-1:0]        nmag;
    logic [QW-1:0]        qr;
    logic signed [CW-1:0] val [2];

    // prep: magnitudes, sign, and quotient overflow test on 2|n|
    dmag = num.d[XW-1] ? DVW'(-num.d) : DVW'(num.d);
    stg_nxt[0].dvs = dmag;
    stg_nxt[0].sel = num.sel;
    stg_nxt[0].deg = (num.d == '0);
    for (int l = 0; l < 2; l++) begin
      n    = (l == 0) ? num.nu : num.nv;
      nmag = n[NW-1] ? NW'(-n) : NW'(n);
      stg_nxt[0].lane[l].rem = {nmag, 1'b0};
      stg_nxt[0].lane[l].quo = '0;
      stg_nxt[0].lane[l].neg = n[NW-1] ^ num.d[XW-1];
      stg_nxt[0].lane[l].ovf = ({nmag, 1'b0} >= (RW'(dmag) << QW));
    end

    for (int i = 0; i < QW; i++) begin
      stg_nxt[i+1] = stg_r[i];
      ds = RW'(stg_r[i].dvs) << (QW - 1 - i);
      for (int l = 0; l < 2; l++) begin
        if (stg_r[i].lane[l].rem >= ds) begin
          stg_nxt[i+1].lane[l].rem = stg_r[i].lane[l].rem - ds;
          stg_nxt[i+1].lane[l].quo = {stg_r[i].lane[l].quo[QW-2:0], 1'b1};
        end else begin
          stg_nxt[i+1].lane[l].quo = {stg_r[i].lane[l].quo[QW-2:0], 1'b0};
        end
      end
    end

    // the lowest bit of floor(2|n|/|d|) is the rounding increment
    for (int l = 0; l < 2; l++) begin
      qr = {1'b0, stg_r[QW].lane[l].quo[QW-1:1]} + QW'(stg_r[QW].lane[l].quo[0]);
      if (stg_r[QW].deg) begin
        val[l] = '0;
      end else if (!stg_r[QW].lane[l].neg) begin
        if (stg_r[QW].lane[l].ovf || qr > QW'(32'h7FFF_FFFF)) begin
          val[l] = 32'sh7FFF_FFFF;
        end else begin
          val[l] = $signed(qr[CW-1:0]);
        end
      end else begin
        if (stg_r[QW].lane[l].ovf || qr > QW'(32'h8000_0000)) begin
          val[l] = $signed(32'h8000_0000);
        end else begin
          val[l] = $signed(CW'(0) - qr[CW-1:0]);
        end
      end
    end
    res_nxt = '{tex_u: val[0], tex_v: val[1], sel: stg_r[QW].sel,
                degenerate: stg_r[QW].deg};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      fin_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[QW-1:0], in_vld};
      fin_vld_r <= vld_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= QW; i++) begin
        stg_r[i] <= stg_nxt[i];
      end
      res_r <= res_nxt;
    end
  end

  assign out_vld = fin_vld_r;
  assign res     = res_r;

endmodule
